### rtl/slot_select_and_status_led_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slot select and status LED controller
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SLOT_SELECT_AND_STATUS_LED_CONTROLLER_MACROS_SVH
`define SLOT_SELECT_AND_STATUS_LED_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SSCL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sscl check failed");

// next-cycle implication
`define SSCL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sscl check failed");

`endif

### rtl/sscl_pkg.sv
// ----------------------------------------------------------------------------
// sscl_pkg
// Types and constants shared by the slot select and status LED controller.
// ----------------------------------------------------------------------------
`default_nettype none

package sscl_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int TIMER_BITS = 16;
  localparam int SLOT_W     = 3;
  localparam int BLINK_W    = 5;
  localparam int CNT_W      = 4;
  localparam int MV_W       = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT     = 3'd0,
    REG_START_SLOT     = 3'd1,
    REG_BLINK_INTERVAL = 3'd2,
    REG_ERROR_INTERVAL = 3'd3,
    REG_SUPPLY_LOW     = 3'd4,
    REG_SUPPLY_HIGH    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic            up_press;
    logic            down_press;
    logic [MV_W-1:0] supply_mv;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              slot_changed;
    logic              slot_led;
    logic              error_led;
    logic              supply_fault;
  } out_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]      slot_count;
    logic [SLOT_W-1:0]     start_slot;
    logic [TIMER_BITS-1:0] blink_interval;
    logic [TIMER_BITS-1:0] error_interval;
    logic [MV_W-1:0]       supply_low_mv;
    logic [MV_W-1:0]       supply_high_mv;
  } cfg_t;

endpackage

`default_nettype wire

### rtl/sscl_cfg.sv
// ----------------------------------------------------------------------------
// sscl_cfg
// Configuration register file, written through the cfg channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sscl_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sscl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sscl_pkg::cfg_t                   cfg
);
  import sscl_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot_count     <= CNT_W'(3);
      cfg.start_slot     <= '0;
      cfg.blink_interval <= TIMER_BITS'(250);
      cfg.error_interval <= TIMER_BITS'(500);
      cfg.supply_low_mv  <= MV_W'(11000);
      cfg.supply_high_mv <= MV_W'(15000);
    end else if (cfg_valid) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SLOT_COUNT:     cfg.slot_count     <= cfg_data[CNT_W-1:0];
        REG_START_SLOT:     cfg.start_slot     <= cfg_data[SLOT_W-1:0];
        REG_BLINK_INTERVAL: cfg.blink_interval <= cfg_data[TIMER_BITS-1:0];
        REG_ERROR_INTERVAL: cfg.error_interval <= cfg_data[TIMER_BITS-1:0];
        REG_SUPPLY_LOW:     cfg.supply_low_mv  <= cfg_data[MV_W-1:0];
        REG_SUPPLY_HIGH:    cfg.supply_high_mv <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sscl_core.sv
// ----------------------------------------------------------------------------
// sscl_core
// Slot, blink and error LED state with its single-tick update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sscl_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  sscl_pkg::in_word_t  word,
  input  sscl_pkg::cfg_t      cfg,
  output sscl_pkg::out_word_t res
);
  import sscl_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  logic                  started;
  logic [SLOT_W-1:0]     active_slot;
  logic [1:0]            pending_presses;
  logic [BLINK_W-1:0]    blinks_left;
  logic [TIMER_BITS-1:0] blink_elapsed;
  logic [TIMER_BITS-1:0] error_elapsed;
  logic                  slot_led_on;
  logic                  error_led_on;

  logic [SLOT_W-1:0]     active_slot_next;
  logic [1:0]            pending_presses_next;
  logic [BLINK_W-1:0]    blinks_left_next;
  logic [TIMER_BITS-1:0] blink_elapsed_next;
  logic [TIMER_BITS-1:0] error_elapsed_next;
  logic                  slot_led_on_next;
  logic                  error_led_on_next;

  logic [SLOT_W-1:0]     last;
  logic                  changed;
  logic                  fault;

  always_comb begin
    priority if (cfg.slot_count == '0)
      last = '0;
    else if (cfg.slot_count > CNT_W'(MAX_SLOTS))
      last = SLOT_W'(MAX_SLOTS - 1);
    else
      last = SLOT_W'(cfg.slot_count - CNT_W'(1));
  end

  always_comb begin
    active_slot_next     = active_slot;
    pending_presses_next = pending_presses | {word.down_press, word.up_press};
    blinks_left_next     = blinks_left;
    slot_led_on_next     = slot_led_on;
    error_led_on_next    = error_led_on;
    changed              = 1'b0;

    blink_elapsed_next = (blink_elapsed == TIMER_MAX) ? TIMER_MAX
                                                      : blink_elapsed + 1'b1;
    error_elapsed_next = (error_elapsed == TIMER_MAX) ? TIMER_MAX
                                                      : error_elapsed + 1'b1;

    if (!started) begin
      active_slot_next   = (cfg.start_slot > last) ? last : cfg.start_slot;
      blinks_left_next   = {1'b0, active_slot_next, 1'b0} + BLINK_W'(2);
      blink_elapsed_next = '0;
    end

    priority if (pending_presses_next[0]) begin
      active_slot_next = (active_slot_next >= last) ? '0
                                                    : active_slot_next + 1'b1;
      pending_presses_next[0] = 1'b0;
      changed = 1'b1;
    end else if (pending_presses_next[1]) begin
      if (active_slot_next == '0 || active_slot_next > last)
        active_slot_next = last;
      else
        active_slot_next = active_slot_next - 1'b1;
      pending_presses_next[1] = 1'b0;
      changed = 1'b1;
    end

    if (changed) begin
      blinks_left_next   = {1'b0, active_slot_next, 1'b0} + BLINK_W'(2);
      blink_elapsed_next = '0;
      slot_led_on_next   = 1'b0;
    end

    if (blinks_left_next != '0 && blink_elapsed_next >= cfg.blink_interval) begin
      blinks_left_next   = blinks_left_next - 1'b1;
      slot_led_on_next   = !slot_led_on_next;
      blink_elapsed_next = '0;
    end

    fault = (word.supply_mv < cfg.supply_low_mv) ||
            (word.supply_mv > cfg.supply_high_mv);
    if (fault) begin
      if (error_elapsed_next > cfg.error_interval) begin
        error_elapsed_next = '0;
        error_led_on_next  = !error_led_on_next;
      end
    end else begin
      error_led_on_next = 1'b0;
    end

    res.slot         = active_slot_next;
    res.slot_changed = changed;
    res.slot_led     = slot_led_on_next;
    res.error_led    = error_led_on_next;
    res.supply_fault = fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started         <= 1'b0;
      active_slot     <= '0;
      pending_presses <= '0;
      blinks_left     <= '0;
      blink_elapsed   <= '0;
      error_elapsed   <= '0;
      slot_led_on     <= 1'b0;
      error_led_on    <= 1'b0;
    end else if (step) begin
      started         <= 1'b1;
      active_slot     <= active_slot_next;
      pending_presses <= pending_presses_next;
      blinks_left     <= blinks_left_next;
      blink_elapsed   <= blink_elapsed_next;
      error_elapsed   <= error_elapsed_next;
      slot_led_on     <= slot_led_on_next;
      error_led_on    <= error_led_on_next;
    end
  end

endmodule

`default_nettype wire

### rtl/slot_select_and_status_led_controller.sv
// ----------------------------------------------------------------------------
// slot_select_and_status_led_controller
// Per-tick slot selection by up/down presses, slot blink code and supply
// window error LED.
//
//   channel  direction  payload        handshake
//   in       input      in_word_t      in_valid / in_ready
//   out      output     out_word_t     out_valid / out_ready
//   cfg      input      index + data   cfg_valid / cfg_ready (always ready)
//
// One tick word per cycle while the output does not stall; each word waits
// in the input register and leaves through the result register. The whole
// tick update is one pass of logic between the two registers. Synchronous
// reset restores the register defaults and clears the valid flags and core
// state. A stalled output holds the result; the input register still takes
// a word when the result register is about to be freed.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_select_and_status_led_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  sscl_pkg::in_word_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output sscl_pkg::out_word_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sscl_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sscl_pkg::*;
  `include "slot_select_and_status_led_controller_macros.svh"

  cfg_t      cfg;
  logic      in_full;
  in_word_t  in_reg;
  logic      advance;
  out_word_t res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  sscl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sscl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .word (in_reg),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  `SSCL_ASSERT_NEXT(a_result_loaded, advance, out_valid)
  `SSCL_ASSERT_NOW(a_changed_led_off,
    out_valid && out_data.slot_changed && cfg.blink_interval != '0, !out_data.slot_led)
  `SSCL_ASSERT_NOW(a_good_supply_no_error, out_valid && !out_data.supply_fault,
    !out_data.error_led)
  `SSCL_ASSERT_NOW(a_no_take_when_full, in_full && out_valid && !out_ready, !in_ready)

endmodule

`default_nettype wire

### sim/slot_led_status_checker.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// slot_led_status_checker
// Watches the tick, status and register channels of the slot selector. Every
// accepted tick word is run through a local copy of the slot, blink and
// supply logic, and each accepted status word is compared field by field
// with the oldest prediction. Hands the outstanding count and the number of
// failures to the testbench top.
// ----------------------------------------------------------------------------
module slot_led_status_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  sscl_pkg::in_word_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  sscl_pkg::out_word_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [sscl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sscl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              due,
  output int                              fail_count
);
  import sscl_pkg::*;

  localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;

  cfg_t                  regs;
  logic                  begun;
  logic [SLOT_W-1:0]     cur_slot;
  logic [1:0]            presses_held;
  logic [BLINK_W-1:0]    blinks_due;
  logic [TIMER_BITS-1:0] blink_timer;
  logic [TIMER_BITS-1:0] fault_timer;
  logic                  slot_lamp;
  logic                  fault_lamp;
  out_word_t             status_due[$];
  out_word_t             want;

  function automatic out_word_t led_tick(input in_word_t t);
    int        last;
    logic      served;
    logic      fault;
    out_word_t r;
    if (regs.slot_count == 0) last = 0;
    else if (regs.slot_count > MAX_SLOTS) last = MAX_SLOTS - 1;
    else last = regs.slot_count - 1;
    served = 1'b0;

    blink_timer = (blink_timer == TIMER_TOP) ? TIMER_TOP : blink_timer + 1'b1;
    fault_timer = (fault_timer == TIMER_TOP) ? TIMER_TOP : fault_timer + 1'b1;

    if (!begun) begin
      begun       = 1'b1;
      cur_slot    = (regs.start_slot > last) ? SLOT_W'(last) : regs.start_slot;
      blinks_due  = BLINK_W'(cur_slot * 2 + 2);
      blink_timer = '0;
    end

    presses_held = presses_held | {t.down_press, t.up_press};

    if (presses_held[0]) begin
      cur_slot        = (cur_slot >= last) ? '0 : cur_slot + 1'b1;
      presses_held[0] = 1'b0;
      served          = 1'b1;
    end else if (presses_held[1]) begin
      cur_slot        = (cur_slot == 0 || cur_slot > last) ? SLOT_W'(last)
                                                           : cur_slot - 1'b1;
      presses_held[1] = 1'b0;
      served          = 1'b1;
    end
    if (served) begin
      blinks_due  = BLINK_W'(cur_slot * 2 + 2);
      blink_timer = '0;
      slot_lamp   = 1'b0;
    end

    if (blinks_due != 0 && blink_timer >= regs.blink_interval) begin
      blinks_due  = blinks_due - 1'b1;
      slot_lamp   = !slot_lamp;
      blink_timer = '0;
    end

    fault = (t.supply_mv < regs.supply_low_mv) || (t.supply_mv > regs.supply_high_mv);
    if (fault) begin
      if (fault_timer > regs.error_interval) begin
        fault_timer = '0;
        fault_lamp  = !fault_lamp;
      end
    end else begin
      fault_lamp = 1'b0;
    end

    r.slot         = cur_slot;
    r.slot_changed = served;
    r.slot_led     = slot_lamp;
    r.error_led    = fault_lamp;
    r.supply_fault = fault;
    return r;
  endfunction

  task automatic report(input string what, input logic [3:0] exp_v, input logic [3:0] got_v);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs.slot_count     = 4'd3;
      regs.start_slot     = 3'd0;
      regs.blink_interval = 16'd250;
      regs.error_interval = 16'd500;
      regs.supply_low_mv  = 16'd11000;
      regs.supply_high_mv = 16'd15000;
      begun        = 1'b0;
      cur_slot     = '0;
      presses_held = '0;
      blinks_due   = '0;
      blink_timer  = '0;
      fault_timer  = '0;
      slot_lamp    = 1'b0;
      fault_lamp   = 1'b0;
      status_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: status word with no tick outstanding, expected none, got %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (out_data.slot !== want.slot) report("slot", want.slot, out_data.slot);
          if (out_data.slot_changed !== want.slot_changed)
            report("slot_changed", want.slot_changed, out_data.slot_changed);
          if (out_data.slot_led !== want.slot_led)
            report("slot_led", want.slot_led, out_data.slot_led);
          if (out_data.error_led !== want.error_led)
            report("error_led", want.error_led, out_data.error_led);
          if (out_data.supply_fault !== want.supply_fault)
            report("supply_fault", want.supply_fault, out_data.supply_fault);
        end
      end
      if (in_valid && in_ready) status_due.push_back(led_tick(in_data));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLOT_COUNT:     regs.slot_count     = cfg_data[CNT_W-1:0];
          REG_START_SLOT:     regs.start_slot     = cfg_data[SLOT_W-1:0];
          REG_BLINK_INTERVAL: regs.blink_interval = cfg_data;
          REG_ERROR_INTERVAL: regs.error_interval = cfg_data;
          REG_SUPPLY_LOW:     regs.supply_low_mv  = cfg_data;
          REG_SUPPLY_HIGH:    regs.supply_high_mv = cfg_data;
          default: ;
        endcase
      end
    end
    due = status_due.size();
  end

endmodule

### sim/slot_select_and_status_led_controller_tb.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// slot_select_and_status_led_controller_tb
// Feeds tick words and register settings to the slot selector: a directed
// walk through wraparound, shrinking slot counts, a single slot, zero blink
// interval and an inverted supply window, then random phases under several
// settings, a long output stall, and a long stretch with no idling.
// Both channels idle at random; the checker beside the block does the
// comparing.
// ----------------------------------------------------------------------------
module slot_select_and_status_led_controller_tb;
  import sscl_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int CHOKE_CYCLES = 300;
  localparam int PHASE_TICKS  = 250;
  localparam int STEADY_TICKS = 150;

  localparam cfg_t EIGHT_INVERTED = '{8, 7, 1, 1, 65535, 0};
  localparam cfg_t THREE_OPEN     = '{3, 7, 1, 1, 0, 65535};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    due;
  int                    fail_count;
  int                    cycles = 0;
  int                    choke_asked = 0;
  int                    choke_done = 0;
  bit                    steady = 1'b0;
  cfg_t                  plan;

  slot_select_and_status_led_controller dut (.*);

  slot_led_status_checker check (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (choke_asked != choke_done) begin
        out_ready <= 1'b0;
        repeat (CHOKE_CYCLES) @(posedge clk);
        choke_done++;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 8);
        @(posedge clk);
      end
    end
  end

  task automatic send_tick(input logic up, input logic dn, input logic [MV_W-1:0] mv);
    while (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{up_press: up, down_press: dn, supply_mv: mv};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_tick();
    logic [MV_W-1:0] mv;
    case ($urandom_range(3))
      0:       mv = MV_W'($urandom);
      1:       mv = MV_W'(plan.supply_low_mv + $urandom_range(2) - 1);
      2:       mv = MV_W'(plan.supply_high_mv + $urandom_range(2) - 1);
      default: mv = MV_W'($urandom_range(plan.supply_low_mv, plan.supply_high_mv));
    endcase
    send_tick($urandom_range(99) < 20, $urandom_range(99) < 20, mv);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // drain the block, then load every register from plan
  task automatic apply_plan();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (due == 0);
    @(posedge clk);
    put_reg(REG_SLOT_COUNT, CFG_DATA_W'(plan.slot_count));
    put_reg(REG_START_SLOT, CFG_DATA_W'(plan.start_slot));
    put_reg(REG_BLINK_INTERVAL, plan.blink_interval);
    put_reg(REG_ERROR_INTERVAL, plan.error_interval);
    put_reg(REG_SUPPLY_LOW, plan.supply_low_mv);
    put_reg(REG_SUPPLY_HIGH, plan.supply_high_mv);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SLOT_COUNT;
    cfg_data  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // start slot past the last slot, blink on every tick
    plan = '{4, 6, 0, 0, 11000, 15000};
    apply_plan();
    send_tick(1'b0, 1'b0, 16'd11000);
    send_tick(1'b1, 1'b0, 16'd15000);
    send_tick(1'b0, 1'b1, 16'd10999);
    send_tick(1'b1, 1'b1, 16'd15001);
    send_tick(1'b0, 1'b0, 16'd0);
    send_tick(1'b1, 1'b0, 16'hFFFF);
    send_tick(1'b0, 1'b0, 16'd12345);

    plan = EIGHT_INVERTED;
    apply_plan();
    send_tick(1'b0, 1'b1, 16'd0);
    send_tick(1'b0, 1'b0, 16'd40000);
    send_tick(1'b0, 1'b0, 16'hFFFF);

    // shrink the slot count under a high slot, step up then down
    plan = THREE_OPEN;
    apply_plan();
    send_tick(1'b1, 1'b0, 16'd1);
    send_tick(1'b0, 1'b0, 16'd2);
    plan = EIGHT_INVERTED;
    apply_plan();
    send_tick(1'b0, 1'b1, 16'd100);
    plan = THREE_OPEN;
    apply_plan();
    send_tick(1'b0, 1'b1, 16'd100);

    plan = '{1, 0, 2, 2, 11000, 15000};
    apply_plan();
    send_tick(1'b1, 1'b0, 16'd11000);
    send_tick(1'b0, 1'b1, 16'd15000);
    send_tick(1'b1, 1'b1, 16'd0);
    send_tick(1'b0, 1'b0, 16'hFFFF);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       plan = '{8, 0, 1, 0, 0, 65535};
        1:       plan = '{0, 5, 0, 65535, 65535, 0};
        2:       plan = '{15, 2, 2, 3, 11000, 15000};
        3:       plan = '{2, 7, 65535, 1, 5000, 60000};
        default: begin
          plan.slot_count     = $urandom_range(15);
          plan.start_slot     = $urandom_range(7);
          plan.blink_interval = $urandom_range(6);
          plan.error_interval = $urandom_range(8);
          plan.supply_low_mv  = $urandom;
          plan.supply_high_mv = $urandom_range(65535, plan.supply_low_mv);
        end
      endcase
      apply_plan();
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if (ph == 2 && n == 40) choke_asked++;
        send_random_tick();
      end
    end

    // run with no idling, then hold a fault against the top interval
    steady = 1'b1;
    plan = '{5, 1, 1, 2, 11000, 15000};
    apply_plan();
    for (int n = 0; n < STEADY_TICKS; n++)
      send_random_tick();
    for (int n = 0; n < 40; n++)
      send_tick(1'b0, 1'b0, n[0] ? 16'd0 : 16'hFFFF);
    plan.error_interval = 16'd65534;
    apply_plan();
    for (int n = 0; n < 10; n++)
      send_tick(1'b0, 1'b0, 16'd0);
    steady = 1'b0;

    in_valid <= 1'b0;
    @(posedge clk);
    wait (due == 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
